>>> design/lsu_pkg.sv
package lsu_pkg;

	// Buffer count and link code widths
	localparam int NUM_BUFFERS = 16;
	localparam int IDX_W       = 4;
	localparam int LINK_W      = 5;

	// Link codes beyond the buffer range
	localparam logic [LINK_W-1:0] LINK_END    = LINK_W'(NUM_BUFFERS);
	localparam logic [LINK_W-1:0] LINK_NOT_IN = LINK_W'(NUM_BUFFERS + 1);

	// Request commands
	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	typedef logic [LINK_W-1:0] link_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Result of one request, passed from the list core to the result register
	typedef struct packed {
		idx_t mru_index;
		idx_t victim_index;
		logic list_empty;
		logic was_present;
	} lsu_result_t;

	// True when a link code names a buffer
	function automatic logic is_buf(input link_t code);
		return code < LINK_W'(NUM_BUFFERS);
	endfunction

endpackage

>>> design/lsu_list_core.sv
module lsu_list_core
	import lsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd_en,
	input  logic        cmd,
	input  idx_t        buf_index,
	output lsu_result_t res
);

	link_t next_q [NUM_BUFFERS];
	link_t prev_q [NUM_BUFFERS];
	link_t head_q;
	link_t tail_q;

	link_t next_d [NUM_BUFFERS];
	link_t prev_d [NUM_BUFFERS];
	link_t head_d;
	link_t tail_d;

	link_t buf_code;
	link_t prev_b;
	link_t next_b;
	logic  present;
	logic  do_detach;
	logic  do_push;
	logic  empty_d;

	// Look up the named buffer's links
	assign buf_code  = LINK_W'(buf_index);
	assign prev_b    = prev_q[buf_index];
	assign next_b    = next_q[buf_index];
	assign present   = (prev_b != LINK_NOT_IN) || (next_b != LINK_NOT_IN);
	assign do_detach = present && ((cmd == CMD_DELETE) || (head_q != buf_code));
	assign do_push   = (cmd == CMD_ACCESS) && (!present || (head_q != buf_code));

	// Unlink, then push at head, on copies of the list
	always_comb begin
		next_d = next_q;
		prev_d = prev_q;
		head_d = head_q;
		tail_d = tail_q;
		if (do_detach) begin
			if (is_buf(prev_b)) begin
				next_d[prev_b[IDX_W-1:0]] = next_b;
			end else begin
				head_d = next_b;
			end
			if (is_buf(next_b)) begin
				prev_d[next_b[IDX_W-1:0]] = prev_b;
			end else begin
				tail_d = prev_b;
			end
			next_d[buf_index] = LINK_NOT_IN;
			prev_d[buf_index] = LINK_NOT_IN;
		end
		if (do_push) begin
			prev_d[buf_index] = LINK_END;
			next_d[buf_index] = head_d;
			if (is_buf(head_d)) begin
				prev_d[head_d[IDX_W-1:0]] = buf_code;
			end else begin
				tail_d = buf_code;
			end
			head_d = buf_code;
		end
	end

	// Report the list as it stands after the request
	always_comb begin
		empty_d          = !is_buf(head_d);
		res.mru_index    = empty_d ? '0 : head_d[IDX_W-1:0];
		res.victim_index = (empty_d || !is_buf(tail_d)) ? '0 : tail_d[IDX_W-1:0];
		res.list_empty   = empty_d;
		res.was_present  = present;
	end

	// Hold the list state; advance it when a request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				next_q[i] <= LINK_NOT_IN;
				prev_q[i] <= LINK_NOT_IN;
			end
			head_q <= LINK_END;
			tail_q <= LINK_END;
		end else if (upd_en) begin
			next_q <= next_d;
			prev_q <= prev_d;
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

endmodule

>>> design/lru_stack_update.sv
// Channel   Direction  Handshake           Payload
// in        request    in_valid/in_stall   cmd, buf_index
// out       result     out_valid/out_stall mru_index, victim_index, list_empty, was_present
//
// One request per cycle sustained while out_stall is low; a result comes from its request
// via the input register, then the result register. The list update sits between them.
// Reset empties the list at once: no clearing pass.
// in_stall rises only while the input register is full and the result register is
// held by out_stall.
module lru_stack_update
	import lsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  idx_t buf_index,
	output logic out_valid,
	input  logic out_stall,
	output idx_t mru_index,
	output idx_t victim_index,
	output logic list_empty,
	output logic was_present
);

	logic        valid_s1;
	logic        cmd_s1;
	idx_t        buf_s1;
	logic        out_valid_q;
	lsu_result_t res_q;
	lsu_result_t res;
	logic        adv;

	// Move the input stage on when the result register is free or being taken
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	lsu_list_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (valid_s1 && adv),
		.cmd       (cmd_s1),
		.buf_index (buf_s1),
		.res       (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= cmd;
			buf_s1 <= buf_index;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign mru_index    = res_q.mru_index;
	assign victim_index = res_q.victim_index;
	assign list_empty   = res_q.list_empty;
	assign was_present  = res_q.was_present;

	// An access leaves the buffer at the head
	a_access_to_head: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && (cmd_s1 == CMD_ACCESS) |=>
			out_valid && !list_empty && (mru_index == $past(buf_s1)))
		else $error("access did not move buffer to head");

	// A deleted buffer is no longer at the head
	a_delete_off_head: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && (cmd_s1 == CMD_DELETE) |=>
			list_empty || (mru_index != $past(buf_s1)))
		else $error("deleted buffer still at head");

	// An empty list reports zero head and victim
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_empty |-> (mru_index == '0) && (victim_index == '0))
		else $error("empty list with nonzero indexes");

endmodule

>>> sim/lru_checker.sv
`timescale 1ns / 100ps

module lru_checker
	import lsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic cmd,
	input  idx_t buf_index,
	input  logic out_valid,
	input  logic out_stall,
	input  idx_t mru_index,
	input  idx_t victim_index,
	input  logic list_empty,
	input  logic was_present,
	input  logic run_done,
	output int   mismatch_count,
	output int   outstanding,
	output int   results_checked,
	output int   hits_seen,
	output int   empties_seen
);

	// Shadow of the recency list
	link_t nxt_of [NUM_BUFFERS];
	link_t prv_of [NUM_BUFFERS];
	link_t top_buf;
	link_t bottom_buf;

	// Results still owed by the block, oldest first
	lsu_result_t lru_expected [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Drop a buffer out of the list, patching its neighbors
	function automatic void unlink_buf(input idx_t b);
		link_t p;
		link_t n;
		p = prv_of[b];
		n = nxt_of[b];
		if (p < LINK_END)
			nxt_of[p[IDX_W-1:0]] = n;
		else
			top_buf = n;
		if (n < LINK_END)
			prv_of[n[IDX_W-1:0]] = p;
		else
			bottom_buf = p;
		nxt_of[b] = LINK_NOT_IN;
		prv_of[b] = LINK_NOT_IN;
	endfunction

	// Put a buffer in front of the current most recent one
	function automatic void link_at_top(input idx_t b);
		prv_of[b] = LINK_END;
		nxt_of[b] = top_buf;
		if (top_buf < LINK_END)
			prv_of[top_buf[IDX_W-1:0]] = link_t'(b);
		else
			bottom_buf = link_t'(b);
		top_buf = link_t'(b);
	endfunction

	// Apply one request to the shadow list and return what the block must answer
	function automatic lsu_result_t predict_update(input logic c, input idx_t b);
		lsu_result_t r;
		logic present;
		logic empty;
		present = (prv_of[b] != LINK_NOT_IN) || (nxt_of[b] != LINK_NOT_IN);
		if (c == CMD_DELETE) begin
			if (present)
				unlink_buf(b);
		end else if (!present) begin
			link_at_top(b);
		end else if (top_buf != link_t'(b)) begin
			unlink_buf(b);
			link_at_top(b);
		end
		empty = !(top_buf < LINK_END);
		r.mru_index    = empty ? '0 : top_buf[IDX_W-1:0];
		r.victim_index = (empty || !(bottom_buf < LINK_END)) ? '0 : bottom_buf[IDX_W-1:0];
		r.list_empty   = empty;
		r.was_present  = present;
		return r;
	endfunction

	// Check results against the oldest expectation, then queue new predictions
	always @(posedge clk or negedge arst_n) begin
		lsu_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				nxt_of[i] = LINK_NOT_IN;
				prv_of[i] = LINK_NOT_IN;
			end
			top_buf = LINK_END;
			bottom_buf = LINK_END;
			lru_expected.delete();
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lru_expected.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected (mru %0d victim %0d)",
						mru_index, victim_index));
				end else begin
					want = lru_expected.pop_front();
					if (mru_index !== want.mru_index)
						report_mismatch($sformatf("result %0d mru_index: expected %0d, got %0d",
							results_checked, want.mru_index, mru_index));
					if (victim_index !== want.victim_index)
						report_mismatch($sformatf("result %0d victim_index: expected %0d, got %0d",
							results_checked, want.victim_index, victim_index));
					if (list_empty !== want.list_empty)
						report_mismatch($sformatf("result %0d list_empty: expected %0d, got %0d",
							results_checked, want.list_empty, list_empty));
					if (was_present !== want.was_present)
						report_mismatch($sformatf("result %0d was_present: expected %0d, got %0d",
							results_checked, want.was_present, was_present));
					if (want.was_present)
						hits_seen++;
					if (want.list_empty)
						empties_seen++;
				end
				results_checked++;
			end
			if (in_valid && !in_stall)
				lru_expected.push_back(predict_update(cmd, buf_index));
			outstanding = lru_expected.size();
		end
	end

	// Flag any result the block never delivered
	always @(posedge run_done) begin
		if (lru_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", lru_expected.size()));
	end

	initial begin
		mismatch_count = 0;
		outstanding = 0;
		results_checked = 0;
		hits_seen = 0;
		empties_seen = 0;
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lsu_pkg::*;

	localparam int RANDOM_REQUESTS = 1400;
	localparam int QUIET_TAIL      = 150;
	localparam int PHASE_LEN       = 100;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd;
	idx_t buf_index;
	logic out_valid;
	logic out_stall;
	idx_t mru_index;
	idx_t victim_index;
	logic list_empty;
	logic was_present;

	logic run_done;
	logic quiet;
	int   mismatch_count;
	int   outstanding;
	int   results_checked;
	int   hits_seen;
	int   empties_seen;
	int   requests_sent;
	int   deletes_sent;

	lru_stack_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.buf_index    (buf_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mru_index    (mru_index),
		.victim_index (victim_index),
		.list_empty   (list_empty),
		.was_present  (was_present)
	);

	lru_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.buf_index       (buf_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mru_index       (mru_index),
		.victim_index    (victim_index),
		.list_empty      (list_empty),
		.was_present     (was_present),
		.run_done        (run_done),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.hits_seen       (hits_seen),
		.empties_seen    (empties_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run hangs
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stall the result side in random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Present one request, after an optional idle burst, and hold it until taken
	task automatic send_request(input logic c, input idx_t b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		buf_index <= b;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		if (c == CMD_DELETE)
			deletes_sent++;
		@(negedge clk);
	endtask

	initial begin
		int   del_pct;
		int   span;
		int   base;
		logic c;
		idx_t b;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ACCESS;
		buf_index = '0;
		run_done = 1'b0;
		quiet = 1'b0;
		requests_sent = 0;
		deletes_sent = 0;
		del_pct = 0;
		span = 16;
		base = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Insert into an empty list, touch the head, empty it, delete absent buffers
		send_request(CMD_ACCESS, 4'd5);
		send_request(CMD_ACCESS, 4'd5);
		send_request(CMD_DELETE, 4'd5);
		send_request(CMD_DELETE, 4'd5);
		send_request(CMD_DELETE, 4'd0);
		// Build 7,15,0 and move tail, middle and head
		send_request(CMD_ACCESS, 4'd0);
		send_request(CMD_ACCESS, 4'd15);
		send_request(CMD_ACCESS, 4'd7);
		send_request(CMD_ACCESS, 4'd0);
		send_request(CMD_ACCESS, 4'd7);
		send_request(CMD_ACCESS, 4'd7);
		// Unlink tail, head and middle, then drain
		send_request(CMD_DELETE, 4'd15);
		send_request(CMD_DELETE, 4'd7);
		send_request(CMD_ACCESS, 4'd10);
		send_request(CMD_ACCESS, 4'd3);
		send_request(CMD_DELETE, 4'd10);
		send_request(CMD_DELETE, 4'd3);
		send_request(CMD_DELETE, 4'd0);
		send_request(CMD_DELETE, 4'd15);
		send_request(CMD_ACCESS, 4'd15);
		send_request(CMD_DELETE, 4'd15);

		// Random phases: each picks a delete mix and a working set
		for (int k = 0; k < RANDOM_REQUESTS; k++) begin
			if (k % PHASE_LEN == 0) begin
				del_pct = $urandom_range(0, 70);
				span = ($urandom_range(0, 2) == 0) ? 16 : $urandom_range(1, 6);
				base = $urandom_range(0, 15);
			end
			if (k >= RANDOM_REQUESTS - QUIET_TAIL)
				quiet = 1'b1;
			c = ($urandom_range(0, 99) < del_pct) ? CMD_DELETE : CMD_ACCESS;
			b = idx_t'(base + $urandom_range(0, span - 1));
			send_request(c, b);
		end
		in_valid <= 1'b0;

		// Drain, let the pipeline settle, then close out
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		run_done = 1'b1;
		@(posedge clk);

		$display("Sent %0d requests (%0d deletes); checked %0d results.",
			requests_sent, deletes_sent, results_checked);
		$display("%0d results found the buffer already listed, %0d showed an empty list.",
			hits_seen, empties_seen);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
